[rtl/chained_hash_set_engine_top_defines.svh]
// Assertion macros used by the engine top.
`ifndef CHAINED_HASH_SET_ENGINE_TOP_DEFINES_SVH
`define CHAINED_HASH_SET_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CHSE_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define CHSE_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define CHSE_ASSERT(label, clk, rstn, prop)
`define CHSE_ASSERT_NR(label, clk, prop)
`endif
`endif

[rtl/chse_pkg.sv]
`timescale 1ns / 1ps
package chse_pkg;
  localparam int unsigned KeyW = 64;
  localparam int unsigned CntW = 13;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Wang style 64-bit integer mix, split into three stages.
  // First stage: complement-add and the first fold.
  function automatic logic [63:0] mix_s1(input logic [63:0] k_in);
    logic [63:0] k;
    k = (~k_in) + (k_in << 21);
    k = k ^ (k >> 24);
    return k;
  endfunction

  // Second stage: multiply by 265 as shifts and adds, then fold.
  function automatic logic [63:0] mix_s2(input logic [63:0] k_in);
    logic [63:0] k;
    k = (k_in + (k_in << 3)) + (k_in << 8);
    k = k ^ (k >> 14);
    return k;
  endfunction

  // Third stage: multiply by 21, fold, and the final shifted add.
  function automatic logic [63:0] mix_s3(input logic [63:0] k_in);
    logic [63:0] k;
    k = (k_in + (k_in << 2)) + (k_in << 4);
    k = k ^ (k >> 28);
    k = k + (k << 31);
    return k;
  endfunction
endpackage

[rtl/chained_hash_set_engine_top.sv]
`timescale 1ns / 1ps
// An accepted word passes through the three hash stages, the modulo unit, the head read and
// the chain walk over the nodes of its bucket before its result is reported.
// One word at a time: a new word is taken only once the last one has reached its result;
// a result left waiting at the output holds up the next result and any bucket count write.
// Reset: bucket count to its maximum, then a clearing pass over all the bucket heads.
// A bucket count write empties the set by the same clearing pass.
`include "chained_hash_set_engine_top_defines.svh"
module chained_hash_set_engine_top #(
  parameter int unsigned MAX_BUCKETS = 4096,
  parameter int unsigned POOL_NODES  = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: key[63:0]
  input  logic [63:0] s_axis_tdata,
  // tuser: operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: success, pool_full, entries_held[12:0], zero fill
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i
);
  import chse_pkg::*;

  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned BD = 1 << BW;
  localparam int unsigned ND = 1 << NW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MIX1 = 3'd2;
  localparam logic [2:0] S_MIX2 = 3'd3;
  localparam logic [2:0] S_MIX3 = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_HEAD = 3'd6;
  localparam logic [2:0] S_CHK  = 3'd7;

  logic [2:0]    st_q, st_d;
  logic [BW-1:0] clr_q;
  logic          op_q;
  logic [63:0]   key_q;
  logic [63:0]   hash_q;
  logic [BW:0]   bc_q;
  logic [NW:0]   used_q;
  logic [BW-1:0] bkt_q;
  logic [NW-1:0] cur_q;
  logic          curv_q;
  logic [NW:0]   steps_q;
  logic          ovalid_q, ovalid_d;
  logic          ok_q, full_q;
  logic [12:0]   ent_q;
  logic          mod_done;
  logic [BW-1:0] mod_rem;
  logic [BW:0]   cfg_eff;

  logic          hit, more, ins_ok, out_free, adv, finish;
  logic          head_we, node_we;
  logic [NW:0]   head_rd, head_wd;
  logic [BW-1:0] head_ra, head_wa;
  logic [NW-1:0] nk_a;
  logic [64+NW:0] node_wd, node_rd;
  logic [63:0]   nkey_rd;
  logic [NW:0]   nlink_rd;

  assign s_axis_tready = (st_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (st_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, ent_q, full_q, ok_q};

  // Clamp a written bucket count to 1..MAX_BUCKETS.
  always_comb begin
    if (cfg_data_i == 13'd0) begin
      cfg_eff = (BW+1)'(1);
    end else if (32'(cfg_data_i) > MAX_BUCKETS) begin
      cfg_eff = (BW+1)'(MAX_BUCKETS);
    end else begin
      cfg_eff = (BW+1)'(cfg_data_i);
    end
  end

  // The last hash stage feeds the modulo unit directly.
  chse_hash_mod #(.IdxW(BW)) u_mod (
    .clk_i, .rst_ni,
    .start_i   (st_q == S_MIX3),
    .hash_i    (mix_s3(hash_q)),
    .divisor_i (bc_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  // Bucket heads carry their valid bit on top.
  assign head_ra = mod_rem;
  chse_ram #(.Width(NW+1), .Depth(BD)) u_heads (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd)
  );

  // Node memory: key in the low bits, link with its valid bit above it.
  assign node_wd  = {head_rd, key_q};
  assign nkey_rd  = node_rd[63:0];
  assign nlink_rd = node_rd[64+NW:64];
  chse_ram #(.Width(65+NW), .Depth(ND)) u_nodes (
    .clk_i, .we_i(node_we), .waddr_i(used_q[NW-1:0]), .wdata_i(node_wd),
    .raddr_i(nk_a), .rdata_o(node_rd)
  );

  // Chain walk decisions for the node currently read.
  assign hit      = curv_q && (nkey_rd == key_q);
  assign more     = curv_q && !hit && nlink_rd[NW] && (steps_q < (NW+1)'(POOL_NODES - 1));
  assign ins_ok   = (op_q == OP_INSERT) && !hit && (used_q < (NW+1)'(POOL_NODES));
  assign out_free = !ovalid_q || m_axis_tready;

  // Sequencer: clear, hash, reduce, fetch head, walk chain, then commit any insert and report.
  always_comb begin
    st_d    = st_q;
    head_we = 1'b0;
    head_wa = bkt_q;
    head_wd = {1'b1, used_q[NW-1:0]};
    node_we = 1'b0;
    nk_a    = cur_q;
    adv     = 1'b0;
    finish  = 1'b0;
    unique case (st_q)
      S_CLR: begin
        head_we = 1'b1;
        head_wa = clr_q;
        head_wd = '0;
        if (clr_q == BW'(BD - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid_i && cfg_ready_o) begin
          st_d = S_CLR;
        end else if (s_axis_tvalid && s_axis_tready) begin
          st_d = S_MIX1;
        end
      end
      S_MIX1: st_d = S_MIX2;
      S_MIX2: st_d = S_MIX3;
      S_MIX3: st_d = S_MOD;
      S_MOD:  if (mod_done) st_d = S_HEAD;
      S_HEAD: begin
        nk_a = head_rd[NW-1:0];
        st_d = S_CHK;
      end
      S_CHK: begin
        if (more) begin
          adv  = 1'b1;
          nk_a = nlink_rd[NW-1:0];
        end else if (out_free) begin
          // The result register is free; commit the insert if one is due, and report.
          finish = 1'b1;
          if (ins_ok) begin
            head_we = 1'b1;
            node_we = 1'b1;
          end
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Result word valid flag.
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    if (finish) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_CLR;
      clr_q    <= '0;
      bc_q     <= (BW+1)'(MAX_BUCKETS);
      used_q   <= '0;
      ovalid_q <= 1'b0;
      curv_q   <= 1'b0;
      steps_q  <= '0;
    end else begin
      st_q     <= st_d;
      ovalid_q <= ovalid_d;
      if (st_q == S_CLR) clr_q <= clr_q + BW'(1);
      if (cfg_valid_i && cfg_ready_o) begin
        bc_q   <= cfg_eff;
        used_q <= '0;
      end else if (finish && ins_ok) begin
        used_q <= used_q + (NW+1)'(1);
      end
      if (st_q == S_HEAD) begin
        curv_q  <= head_rd[NW];
        steps_q <= '0;
      end else if (adv) begin
        curv_q  <= nlink_rd[NW];
        steps_q <= steps_q + (NW+1)'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tuser;
      key_q <= s_axis_tdata;
    end
    if (st_q == S_MIX1) begin
      hash_q <= mix_s1(key_q);
    end else if (st_q == S_MIX2) begin
      hash_q <= mix_s2(hash_q);
    end
    if (mod_done) bkt_q <= mod_rem;
    if (st_q == S_HEAD) begin
      cur_q <= head_rd[NW-1:0];
    end else if (adv) begin
      cur_q <= nlink_rd[NW-1:0];
    end
    if (finish) begin
      if (hit) begin
        ok_q   <= 1'b1;
        full_q <= 1'b0;
        ent_q  <= 13'(used_q);
      end else if (ins_ok) begin
        ok_q   <= 1'b1;
        full_q <= 1'b0;
        ent_q  <= 13'(used_q + (NW+1)'(1));
      end else begin
        ok_q   <= 1'b0;
        full_q <= (op_q == OP_INSERT);
        ent_q  <= 13'(used_q);
      end
    end
  end

  `CHSE_ASSERT(a_nofill, clk_i, rst_ni, node_we |-> used_q < (NW+1)'(POOL_NODES))
  `CHSE_ASSERT(a_used_max, clk_i, rst_ni, used_q <= (NW+1)'(POOL_NODES))
  `CHSE_ASSERT(a_busy_block, clk_i, rst_ni, st_q != S_IDLE |-> !s_axis_tready)
  `CHSE_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
endmodule

[rtl/chse_ram.sv]
`timescale 1ns / 1ps
module chse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/chse_hash_mod.sv]
`timescale 1ns / 1ps
module chse_hash_mod #(
  parameter int unsigned IdxW = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      hash_i,
  input  logic [IdxW:0]    divisor_i,
  output logic             done_o,
  output logic [IdxW-1:0]  rem_o
);
  import chse_pkg::*;

  localparam int unsigned CW = 7;
  localparam int unsigned BitsPerStep = 4;

  logic [63:0]   num_q, num_d;
  logic [IdxW:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  // Restoring remainder, four bits of the dividend per cycle.
  always_comb begin
    logic [IdxW+1:0] r;
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    r      = '0;
    if (start_i) begin
      num_d  = hash_i;
      rem_d  = '0;
      cnt_d  = CW'(64 / BitsPerStep);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r = {1'b0, rem_q};
      for (int i = 0; i < BitsPerStep; i++) begin
        r = {r[IdxW:0], num_d[63]};
        num_d = num_d << 1;
        if (r >= {1'b0, divisor_i}) begin
          r = r - {1'b0, divisor_i};
        end
      end
      rem_d = r[IdxW:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IdxW-1:0];
endmodule

[tb/sv/tb_chained_hash_set_engine_top.sv]
`timescale 1ns / 1ps
module tb_chained_hash_set_engine_top;
  import chse_pkg::*;

  localparam int unsigned NBuckets = 4096;
  localparam int unsigned NNodes   = 4096;
  localparam longint unsigned CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: key[63:0]
  logic [63:0] s_axis_tdata = '0;
  // tuser: operation
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: success, pool_full, entries_held[12:0], zero fill
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint unsigned cycle_count = 0;
  logic [63:0] phase_keys[$];

  typedef struct packed {
    logic        success;
    logic        pool_full;
    logic [12:0] entries_held;
  } lookup_result_t;

  chained_hash_set_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the hash set with its own lookup and insert logic.
  class hash_set_scoreboard;
    int          head_node[NBuckets];
    logic [63:0] node_key[NNodes];
    int          next_node[NNodes];
    int unsigned nodes_used;
    int unsigned buckets;
    lookup_result_t pending[$];
    int unsigned mismatches;
    int unsigned words_checked;

    function automatic logic [63:0] scramble(logic [63:0] k_in);
      logic [63:0] k;
      k = (~k_in) + (k_in << 21);
      k = k ^ (k >> 24);
      k = (k + (k << 3)) + (k << 8);
      k = k ^ (k >> 14);
      k = (k + (k << 2)) + (k << 4);
      k = k ^ (k >> 28);
      k = k + (k << 31);
      return k;
    endfunction

    function void set_buckets(logic [12:0] value);
      buckets = (value == 0) ? 1 : (value > NBuckets) ? NBuckets : value;
      foreach (head_node[i]) head_node[i] = -1;
      nodes_used = 0;
    endfunction

    // Works out the result word that one accepted operation should produce.
    function void note_input(logic op, logic [63:0] key);
      int bucket;
      int n;
      bit found;
      lookup_result_t res;
      bucket = int'(scramble(key) % 64'(buckets));
      n = head_node[bucket];
      found = 1'b0;
      while (n >= 0 && !found) begin
        if (node_key[n] == key) found = 1'b1;
        n = next_node[n];
      end
      res = '0;
      if (found) begin
        res.success = 1'b1;
      end else if (op == OP_INSERT) begin
        if (nodes_used < NNodes) begin
          node_key[nodes_used] = key;
          next_node[nodes_used] = head_node[bucket];
          head_node[bucket] = nodes_used;
          nodes_used++;
          res.success = 1'b1;
        end else begin
          res.pool_full = 1'b1;
        end
      end
      res.entries_held = 13'(nodes_used);
      pending.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    endtask

    task check_result(logic [15:0] word);
      lookup_result_t want;
      words_checked++;
      if (pending.size() == 0) begin
        report("unexpected result word", 32'(word), 32'd0);
        return;
      end
      want = pending.pop_front();
      if (word[0] !== want.success) report("success", 32'(word[0]), 32'(want.success));
      if (word[1] !== want.pool_full) report("pool_full", 32'(word[1]), 32'(want.pool_full));
      if (word[14:2] !== want.entries_held)
        report("entries_held", 32'(word[14:2]), 32'(want.entries_held));
      if (word[15] !== 1'b0) report("zero fill", 32'(word[15]), 32'd0);
    endtask
  endclass

  hash_set_scoreboard sb = new();

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Both handshakes are observed on the same edge the block sees them.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_buckets(logic [12:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_buckets(value);
    phase_keys.delete();
  endtask

  task automatic send_word(logic op, logic [63:0] key);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_INSERT) phase_keys.push_back(key);
  endtask

  function automatic logic [63:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45 && phase_keys.size() != 0)
      return phase_keys[$urandom_range(0, phase_keys.size() - 1)];
    if (r < 48) return '0;
    if (r < 51) return '1;
    return {$urandom, $urandom};
  endfunction

  // One setting of the bucket count with a random mix of inserts and queries.
  task automatic run_phase(logic [12:0] bc, int n, int unsigned sp, int unsigned rp);
    write_buckets(bc);
    send_idle_pct = sp;
    recv_stall_pct = rp;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
      send_word(($urandom_range(0, 99) < 55) ? OP_INSERT : OP_QUERY, pick_key());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    sb.set_buckets(13'(NBuckets));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queries, extreme keys, duplicates and misses.
    send_word(OP_QUERY, '0);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, '1);
    send_word(OP_QUERY, '0);
    send_word(OP_QUERY, '1);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, 64'h8000_0000_0000_0000);
    send_word(OP_QUERY, 64'h0000_0000_0000_0001);
    send_word(OP_INSERT, 64'h0000_0000_0000_0001);
    send_word(OP_QUERY, 64'h8000_0000_0000_0000);
    send_word(OP_QUERY, 64'h5555_aaaa_5555_aaaa);
    send_word(OP_INSERT, '1);
    s_axis_tvalid <= 1'b0;

    // Random phases across bucket counts, including the clamped ones.
    run_phase(13'd0, 120, 0, 0);
    run_phase(13'd1, 120, 48, 0);
    run_phase(13'd8191, 300, 0, 48);
    run_phase(13'd13, 250, 22, 22);
    run_phase(13'd4095, 300, 48, 0);
    run_phase(13'd4097, 250, 0, 0);
    run_phase(13'd2, 150, 22, 22);
    run_phase(13'd4096, 350, 0, 48);

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Checked %0d result words over nine bucket count settings, clamped ones included,",
             sb.words_checked);
    $display("under four mixes of sender idling and receiver stalls.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
